>>> hdl/pcsv_pkg.sv
// Shared types, constants and helper functions for the PNG chunk structure validator.
// No dependencies; every other file in hdl/ except pcsv_in_if refers to this package by scoped names.
package pcsv_pkg;

    localparam int LENGTH_BITS_DEF = 32;

    localparam int SIG_BYTES       = 8;
    localparam int HDR_FIELD_BYTES = 4;
    localparam int CRC_BYTES       = 4;

    localparam int STATUS_BITS = 3;
    localparam int IMG_LEN_BITS = 32;

    localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_BAD_SIG  = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_NO_IHDR  = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_DUP_IHDR = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_BAD_NAME = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_TRUNC    = 3'd5;

    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    typedef struct packed {
        logic [STATUS_BITS-1:0]  status;
        logic [IMG_LEN_BITS-1:0] image_length;
    } res_t;

    // PNG signature: 89 50 4E 47 0D 0A 1A 0A
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            3'd7:    b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
    endfunction

endpackage

>>> hdl/pcsv_in_if.sv
// Byte stream channel: valid/ready handshake carrying one stream byte and its last mark.
// No dependencies.
interface pcsv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> hdl/pcsv_out_if.sv
// Result channel: valid/ready handshake carrying status and image length.
// Depends on pcsv_pkg for field widths.
interface pcsv_out_if;
    logic                               valid;
    logic                               ready;
    logic [pcsv_pkg::STATUS_BITS-1:0]   status;
    logic [pcsv_pkg::IMG_LEN_BITS-1:0]  image_length;

    modport source (output valid, output status, output image_length, input ready);
    modport sink   (input valid, input status, input image_length, output ready);
endinterface

>>> hdl/pcsv_core.sv
// Parser state machine: signature check, chunk header parse, data/CRC skip counting.
// Depends on pcsv_pkg.
module pcsv_core #(
    parameter int LENGTH_BITS = pcsv_pkg::LENGTH_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    output logic            res_valid,
    output pcsv_pkg::res_t  res
);

    localparam logic [2:0] SIG_LAST   = 3'(pcsv_pkg::SIG_BYTES - 1);
    localparam logic [2:0] FIELD_LAST = 3'(pcsv_pkg::HDR_FIELD_BYTES - 1);
    localparam int         EXT_BITS   = (LENGTH_BITS > pcsv_pkg::IMG_LEN_BITS) ?
                                        LENGTH_BITS : pcsv_pkg::IMG_LEN_BITS + 1;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_SKIP,
        PH_DONE
    } phase_t;

    phase_t                 phase_reg,  phase_next;
    logic [2:0]             fbc_reg,    fbc_next;
    logic [31:0]            len_reg,    len_next;
    logic [23:0]            type_reg,   type_next;
    logic [32:0]            skip_reg,   skip_next;
    logic [LENGTH_BITS-1:0] total_reg,  total_next;
    logic                   hdr_reg,    hdr_next;
    logic                   iend_reg,   iend_next;

    logic [31:0]            type_word;
    logic                   hdr_now;
    logic                   hit;
    logic [pcsv_pkg::STATUS_BITS-1:0] hit_status;
    logic [EXT_BITS-1:0]    total_ext;

    assign type_word = {type_reg, data_byte};
    assign total_ext = EXT_BITS'(total_next);

    always_comb
    begin
        phase_next = phase_reg;
        fbc_next   = fbc_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        skip_next  = skip_reg;
        total_next = total_reg;
        hdr_next   = hdr_reg;
        iend_next  = iend_reg;
        hit        = 1'b0;
        hit_status = pcsv_pkg::ST_OK;
        hdr_now    = hdr_reg | (type_word == pcsv_pkg::TYPE_IHDR);

        if (phase_reg != PH_DONE && !(&total_reg))
        begin
            total_next = total_reg + LENGTH_BITS'(1);
        end

        case (phase_reg)
            PH_SIG:
            begin
                if (data_byte != pcsv_pkg::sig_byte(fbc_reg))
                begin
                    phase_next = PH_DONE;
                    hit        = 1'b1;
                    hit_status = pcsv_pkg::ST_BAD_SIG;
                end
                else if (fbc_reg == SIG_LAST)
                begin
                    fbc_next   = 3'd0;
                    len_next   = '0;
                    phase_next = PH_LEN;
                end
                else
                begin
                    fbc_next = fbc_reg + 3'd1;
                end
            end
            PH_LEN:
            begin
                len_next = {len_reg[23:0], data_byte};
                if (fbc_reg == FIELD_LAST)
                begin
                    fbc_next   = 3'd0;
                    type_next  = '0;
                    phase_next = PH_TYPE;
                end
                else
                begin
                    fbc_next = fbc_reg + 3'd1;
                end
            end
            PH_TYPE:
            begin
                type_next = type_word[23:0];
                if (fbc_reg != FIELD_LAST)
                begin
                    fbc_next = fbc_reg + 3'd1;
                end
                else
                begin
                    fbc_next = 3'd0;
                    hit      = 1'b1;
                    // checks in priority order: duplicate IHDR, missing IHDR, bad name
                    if (type_word == pcsv_pkg::TYPE_IHDR && hdr_reg)
                    begin
                        hit_status = pcsv_pkg::ST_DUP_IHDR;
                    end
                    else if (!hdr_now)
                    begin
                        hit_status = pcsv_pkg::ST_NO_IHDR;
                    end
                    else if (!(pcsv_pkg::is_letter(type_word[31:24]) &&
                               pcsv_pkg::is_letter(type_word[23:16]) &&
                               pcsv_pkg::is_letter(type_word[15:8])  &&
                               pcsv_pkg::is_letter(type_word[7:0])))
                    begin
                        hit_status = pcsv_pkg::ST_BAD_NAME;
                    end
                    else
                    begin
                        hit = 1'b0;
                    end

                    if (hit)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        hdr_next   = 1'b1;
                        iend_next  = iend_reg | (type_word == pcsv_pkg::TYPE_IEND);
                        skip_next  = {1'b0, len_reg} + 33'(pcsv_pkg::CRC_BYTES);
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                // counter is loaded with at least the CRC size, so never zero here
                skip_next = skip_reg - 33'd1;
                if (skip_reg == 33'd1)
                begin
                    if (iend_reg)
                    begin
                        phase_next = PH_DONE;
                        hit        = 1'b1;
                        hit_status = pcsv_pkg::ST_OK;
                    end
                    else
                    begin
                        len_next   = '0;
                        phase_next = PH_LEN;
                    end
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        res_valid        = fire && (hit || (last_byte && phase_reg != PH_DONE));
        res.status       = hit ? hit_status : pcsv_pkg::ST_TRUNC;
        res.image_length = '0;
        if (hit && hit_status == pcsv_pkg::ST_OK)
        begin
            res.image_length = (|total_ext[EXT_BITS-1:pcsv_pkg::IMG_LEN_BITS]) ? '1 :
                               total_ext[pcsv_pkg::IMG_LEN_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIG;
            fbc_reg   <= '0;
            len_reg   <= '0;
            type_reg  <= '0;
            skip_reg  <= '0;
            total_reg <= '0;
            hdr_reg   <= 1'b0;
            iend_reg  <= 1'b0;
        end
        else if (fire)
        begin
            if (last_byte)
            begin
                // end of buffer rearms the parser
                phase_reg <= PH_SIG;
                fbc_reg   <= '0;
                len_reg   <= '0;
                type_reg  <= '0;
                skip_reg  <= '0;
                total_reg <= '0;
                hdr_reg   <= 1'b0;
                iend_reg  <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                fbc_reg   <= fbc_next;
                len_reg   <= len_next;
                type_reg  <= type_next;
                skip_reg  <= skip_next;
                total_reg <= total_next;
                hdr_reg   <= hdr_next;
                iend_reg  <= iend_next;
            end
        end
    end

endmodule

>>> hdl/pcsv_out_reg.sv
// Result register driving the output channel; reports space for the next result.
// Depends on pcsv_pkg and pcsv_out_if.
module pcsv_out_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  pcsv_pkg::res_t  res,
    output logic            space,
    pcsv_out_if.source      verdict
);

    logic           valid_reg;
    pcsv_pkg::res_t res_reg;

    assign space                = !valid_reg || verdict.ready;
    assign verdict.valid        = valid_reg;
    assign verdict.status       = res_reg.status;
    assign verdict.image_length = res_reg.image_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (verdict.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

>>> hdl/png_chunk_structure_validator.sv
// Top level of the PNG chunk structure validator: input register, parser core, result register.
// Depends on pcsv_pkg, pcsv_in_if, pcsv_out_if, pcsv_core and pcsv_out_reg.
//
//   Channel   Dir  Payload                         Transfer
//   stream    in   data_byte[7:0], last_byte       valid & ready
//   verdict   out  status[2:0], image_length[31:0] valid & ready
//
// Throughput is one byte per cycle while the result register has space: each byte goes
// input register -> parser step logic -> result register, and a byte that ends an image
// loads its result as it leaves the input register. The critical path is the 33-bit skip counter / length compare.
// Reset (rst_n, async low) empties both registers and puts the parser in signature phase.
// A stalled verdict channel holds the parser only once a byte waits in the input
// register and the result register is still full; the stream side then drops ready.
module png_chunk_structure_validator #(
    parameter int LENGTH_BITS = pcsv_pkg::LENGTH_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pcsv_in_if.sink     stream,
    pcsv_out_if.source  verdict
);

    logic           in_valid_reg;
    logic [7:0]     in_data_reg;
    logic           in_last_reg;

    logic           space;
    logic           proc_fire;
    logic           res_valid;
    pcsv_pkg::res_t res;

    // a byte leaves the input register once the result register can take its result
    assign proc_fire    = in_valid_reg && space;
    assign stream.ready = !in_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            in_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_data_reg <= stream.data_byte;
            in_last_reg <= stream.last_byte;
        end
    end

    pcsv_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (proc_fire),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    pcsv_out_reg u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (res_valid),
        .res     (res),
        .space   (space),
        .verdict (verdict)
    );

endmodule
